// File: design/dq_pkg.sv
package dq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [2:0] FN_INS_FRONT = 3'd0;
	localparam logic [2:0] FN_INS_BACK  = 3'd1;
	localparam logic [2:0] FN_REM_FRONT = 3'd2;
	localparam logic [2:0] FN_REM_BACK  = 3'd3;
	localparam logic [2:0] FN_LIST      = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		OP_INS_FRONT,
		OP_INS_BACK,
		OP_REM_FRONT,
		OP_REM_BACK,
		OP_LIST,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] item_value;
		logic [4:0]         entry_count;
		logic [1:0]         status;
		logic               last;
	} rsp_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
	} cmd_t;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

endpackage

// File: design/dq_ram.sv
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/dq_front.sv
module dq_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dq_pkg::req_t  req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output dq_pkg::cmd_t  cmd
);

	dq_pkg::cmd_t cmd_d;
	dq_pkg::cmd_t slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         push;
	logic         pop;

	always_comb begin
		cmd_d.value = req.value;
		unique case (req.func)
			dq_pkg::FN_INS_FRONT: cmd_d.op = dq_pkg::OP_INS_FRONT;
			dq_pkg::FN_INS_BACK:  cmd_d.op = dq_pkg::OP_INS_BACK;
			dq_pkg::FN_REM_FRONT: cmd_d.op = dq_pkg::OP_REM_FRONT;
			dq_pkg::FN_REM_BACK:  cmd_d.op = dq_pkg::OP_REM_BACK;
			dq_pkg::FN_LIST:      cmd_d.op = dq_pkg::OP_LIST;
			default:              cmd_d.op = dq_pkg::OP_NOP;
		endcase
	end

	assign req_ready = (count_q != 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/dq_back.sv
module dq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  dq_pkg::cmd_t  cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dq_pkg::rsp_t  rsp
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_LIST = 1'b1;

	logic                     state_q, state_d;
	logic [dq_pkg::IDX_W-1:0] head_q, head_d;
	logic [dq_pkg::IDX_W-1:0] tail_q, tail_d;
	logic [dq_pkg::CNT_W-1:0] occ_q, occ_d;
	logic [dq_pkg::IDX_W-1:0] rd_ptr_q, rd_ptr_d;
	logic [dq_pkg::CNT_W-1:0] left_q, left_d;
	logic                     rsp_valid_q;
	dq_pkg::rsp_t             rsp_q, rsp_d;
	logic                     load_rsp;
	logic                     out_free;
	logic                     take;
	logic                     full;
	logic                     empty;

	logic                     ram_we;
	logic [dq_pkg::IDX_W-1:0] ram_waddr;
	logic                     ram_re;
	logic [dq_pkg::IDX_W-1:0] ram_raddr;
	logic [31:0]              ram_rdata;

	dq_ram #(
		.WIDTH (32),
		.DEPTH (dq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == S_IDLE) && out_free;
	assign take      = cmd_valid && cmd_ready;
	assign full      = (occ_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
	assign empty     = (occ_q == '0);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		occ_d     = occ_q;
		rd_ptr_d  = rd_ptr_q;
		left_d    = left_q;
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		load_rsp  = 1'b0;
		rsp_d     = rsp_q;

		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					rsp_d.item_value = '0;
					rsp_d.status     = dq_pkg::ST_OK;
					rsp_d.last       = 1'b1;
					load_rsp         = 1'b1;
					unique case (cmd.op)
						dq_pkg::OP_INS_FRONT: begin
							if (full) begin
								rsp_d.status = dq_pkg::ST_FULL;
							end else begin
								head_d    = dq_pkg::idx_dec(head_q);
								ram_we    = 1'b1;
								ram_waddr = head_d;
								occ_d     = occ_q + 1'b1;
							end
						end
						dq_pkg::OP_INS_BACK: begin
							if (full) begin
								rsp_d.status = dq_pkg::ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = tail_q;
								tail_d    = dq_pkg::idx_inc(tail_q);
								occ_d     = occ_q + 1'b1;
							end
						end
						dq_pkg::OP_REM_FRONT: begin
							if (empty) begin
								rsp_d.status = dq_pkg::ST_EMPTY;
							end else begin
								head_d = dq_pkg::idx_inc(head_q);
								occ_d  = occ_q - 1'b1;
							end
						end
						dq_pkg::OP_REM_BACK: begin
							if (empty) begin
								rsp_d.status = dq_pkg::ST_EMPTY;
							end else begin
								tail_d = dq_pkg::idx_dec(tail_q);
								occ_d  = occ_q - 1'b1;
							end
						end
						dq_pkg::OP_LIST: begin
							if (empty) begin
								rsp_d.status = dq_pkg::ST_EMPTY;
							end else begin
								// first read goes out now, results follow from rdata
								load_rsp  = 1'b0;
								ram_re    = 1'b1;
								ram_raddr = head_q;
								rd_ptr_d  = head_q;
								left_d    = occ_q;
								state_d   = S_LIST;
							end
						end
						default: begin
						end
					endcase
					rsp_d.entry_count = 5'(occ_d);
				end
			end
			S_LIST: begin
				if (out_free) begin
					load_rsp          = 1'b1;
					rsp_d.item_value  = ram_rdata;
					rsp_d.entry_count = 5'(occ_q);
					rsp_d.status      = dq_pkg::ST_OK;
					rsp_d.last        = (left_q == dq_pkg::CNT_W'(1));
					if (left_q == dq_pkg::CNT_W'(1)) begin
						state_d = S_IDLE;
					end else begin
						// fetch the next entry while this one goes out
						rd_ptr_d  = dq_pkg::idx_inc(rd_ptr_q);
						ram_re    = 1'b1;
						ram_raddr = rd_ptr_d;
						left_d    = left_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
		rd_ptr_q <= rd_ptr_d;
		left_q   <= left_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			occ_q   <= occ_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: design/double_ended_queue_top.sv
// channel | handshake             | payload            | direction
// request | req_valid / req_ready | req (dq_pkg::req_t) | in
// result  | rsp_valid / rsp_ready | rsp (dq_pkg::rsp_t) | out
//
// an insert, removal or unused code passes through the command queue, and its result is
// registered in the result register when the back end takes the command from that queue;
// a new request can follow every cycle while results are taken and no listing is under way.
// a listing holds the back end until its last entry is out: one store read per entry
// through the single read port, the first at acceptance, each next one as the last goes out.
// arst_n clears head, tail, queue pointers, counts and both handshake stages; not the store.
// a stalled result holds the back end; the two-entry command queue takes up to two more.
module double_ended_queue_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dq_pkg::req_t  req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dq_pkg::rsp_t  rsp
);

	logic         cmd_valid;
	logic         cmd_ready;
	dq_pkg::cmd_t cmd;

	dq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	dq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: design/dq_chk.sv
module dq_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input dq_pkg::req_t  req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input dq_pkg::rsp_t  rsp
);

	// a pending result stays put until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
	else $error("result changed or dropped while stalled");

	// a waiting request holds still until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
	else $error("request changed or dropped while stalled");

	// empty and full reports are single results with no value
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != dq_pkg::ST_OK |-> rsp.last && rsp.item_value == '0)
	else $error("error result not final or carries a value");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (dq_pkg::DEPTH > 31) || (rsp.entry_count <= 5'(dq_pkg::DEPTH)))
	else $error("entry count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == dq_pkg::ST_FULL
			|-> (dq_pkg::DEPTH > 31) || (rsp.entry_count == 5'(dq_pkg::DEPTH)))
	else $error("full refusal without a full queue");

endmodule

bind double_ended_queue_top dq_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// File: tb/deque_checker.sv
module deque_checker
	import dq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   fail_count,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [31:0] ring [DEPTH];
	int head;
	int fill;
	rsp_t pending_results[$];

	function automatic rsp_t make_result(input logic signed [31:0] v, input logic [1:0] st,
			input logic fin);
		rsp_t r;
		r.item_value  = v;
		r.entry_count = 5'(fill);
		r.status      = st;
		r.last        = fin;
		return r;
	endfunction

	task automatic apply_request(input req_t r);
		case (r.func)
			FN_INS_FRONT, FN_INS_BACK: begin
				if (fill >= DEPTH) begin
					pending_results.push_back(make_result('0, ST_FULL, 1'b1));
				end else begin
					if (r.func == FN_INS_FRONT) begin
						head = (head + DEPTH - 1) % DEPTH;
						ring[head] = r.value;
					end else begin
						ring[(head + fill) % DEPTH] = r.value;
					end
					fill++;
					pending_results.push_back(make_result('0, ST_OK, 1'b1));
				end
			end
			FN_REM_FRONT, FN_REM_BACK: begin
				if (fill == 0) begin
					pending_results.push_back(make_result('0, ST_EMPTY, 1'b1));
				end else begin
					// back removal only shrinks the count, the slot stays as written
					if (r.func == FN_REM_FRONT)
						head = (head + 1) % DEPTH;
					fill--;
					pending_results.push_back(make_result('0, ST_OK, 1'b1));
				end
			end
			FN_LIST: begin
				if (fill == 0) begin
					pending_results.push_back(make_result('0, ST_EMPTY, 1'b1));
				end else begin
					for (int i = 0; i < fill; i++)
						pending_results.push_back(make_result(ring[(head + i) % DEPTH],
							ST_OK, i == fill - 1));
				end
			end
			default: begin
				pending_results.push_back(make_result('0, ST_OK, 1'b1));
			end
		endcase
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (pending_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: result with nothing expected: %0s %0d %0d %0d %0d",
					$realtime, "value/count/status/last", got.item_value,
					got.entry_count, got.status, got.last);
			return;
		end
		want = pending_results.pop_front();
		if (got.item_value !== want.item_value || got.entry_count !== want.entry_count ||
				got.status !== want.status || got.last !== want.last) begin
			fail_count++;
			if (fail_count <= 10)
				$display({"%0t: mismatch exp value %0d count %0d status %0d last %0d,",
					" got value %0d count %0d status %0d last %0d"},
					$realtime, want.item_value, want.entry_count, want.status,
					want.last, got.item_value, got.entry_count, got.status, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			fill = 0;
			pending_results.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			// results trail their request through the command queue and result register, so check first
			if (rsp_valid && rsp_ready)
				check_result(rsp);
			if (req_valid && req_ready)
				apply_request(req);
			outstanding = pending_results.size();
		end
	end

endmodule

// File: tb/double_ended_queue_top_tb.sv
module double_ended_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dq_pkg::*;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	int   fail_count;
	int   outstanding;
	bit   idle_off;
	int   hold;

	double_ended_queue_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	deque_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 8);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(15))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_unused();
		return 3'($urandom_range(7, FN_LIST + 1));
	endfunction

	function automatic logic [2:0] pick_removal();
		return $urandom_range(1) ? FN_REM_FRONT : FN_REM_BACK;
	endfunction

	function automatic logic [2:0] pick_func(input phase_e ph);
		int roll;
		roll = $urandom_range(99);
		case (ph)
			PH_FILL: begin
				if (roll < 40) return FN_INS_FRONT;
				if (roll < 80) return FN_INS_BACK;
				if (roll < 85) return pick_removal();
				if (roll < 95) return FN_LIST;
				return pick_unused();
			end
			PH_DRAIN: begin
				if (roll < 35) return FN_REM_FRONT;
				if (roll < 70) return FN_REM_BACK;
				if (roll < 80) return $urandom_range(1) ? FN_INS_FRONT : FN_INS_BACK;
				if (roll < 95) return FN_LIST;
				return pick_unused();
			end
			default: begin
				if (roll < 22) return FN_INS_FRONT;
				if (roll < 44) return FN_INS_BACK;
				if (roll < 60) return FN_REM_FRONT;
				if (roll < 76) return FN_REM_BACK;
				if (roll < 94) return FN_LIST;
				return pick_unused();
			end
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(input logic [2:0] f, input logic signed [31:0] v);
		int gap;
		gap = (!idle_off && $urandom_range(99) < 30) ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.func  <= f;
		req.value <= v;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
	endtask

	initial begin
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!idle_off && $urandom_range(99) < 25) begin
				rsp_ready <= 1'b0;
				hold = pick_gap() - 1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		phase_e plan [6];
		req_valid = 1'b0;
		req       = '0;
		rsp_ready = 1'b0;
		arst_n    = 1'b0;
		idle_off  = 1'b0;
		plan = '{PH_FILL, PH_MIXED, PH_DRAIN, PH_FILL, PH_MIXED, PH_DRAIN};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// on the empty queue every removal and the listing report empty
		send_request(FN_LIST, pick_value());
		send_request(FN_REM_FRONT, pick_value());
		send_request(FN_REM_BACK, pick_value());
		send_request(FN_INS_FRONT, 32'sh7fffffff);
		send_request(FN_INS_BACK, 32'sh80000000);
		send_request(FN_INS_FRONT, '0);
		send_request(FN_INS_BACK, -32'sd1);
		send_request(FN_INS_FRONT, 32'sd1);
		send_request(FN_LIST, pick_value());
		send_request(FN_LIST + 3'd1, -32'sd1);
		send_request(FN_LIST + 3'd2, 32'sh55555555);
		send_request(FN_LIST + 3'd3, 32'shaaaaaaaa);
		send_request(FN_REM_BACK, pick_value());
		send_request(FN_REM_FRONT, pick_value());
		send_request(FN_LIST, pick_value());
		send_request(FN_REM_FRONT, pick_value());
		send_request(FN_REM_FRONT, pick_value());
		send_request(FN_REM_BACK, pick_value());
		send_request(FN_REM_BACK, pick_value());

		// fill phases run into the full limit, drain phases into empty
		for (int ph = 0; ph < 6; ph++) begin
			idle_off = (ph == 1 || ph == 3);
			for (int n = 0; n < 22; n++)
				send_request(pick_func(plan[ph]), pick_value());
		end

		req_valid <= 1'b0;
		idle_off = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: double_ended_queue_top.f
design/dq_pkg.sv
design/dq_ram.sv
design/dq_front.sv
design/dq_back.sv
design/double_ended_queue_top.sv
design/dq_chk.sv
tb/deque_checker.sv
tb/double_ended_queue_top_tb.sv
